@@ hw/rtl/bbc_pkg.sv @@
// ---------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the buffer cache slot manager
// Request and status codes, the stored slot entry and controller signals.
// ---------------------------------------------------------------------------
package bbc_pkg;

  localparam int NUM_SLOTS_DEF = 32;

  localparam int SLOT_W   = 5;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int CNT_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int S_DATA_W = 80;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_UNDER  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_LOOKUP,
    S_MODIFY,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    status_e           status;
    logic              fill;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } result_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic modify;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic in_get;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/bbc_ctrl.sv @@
// ---------------------------------------------------------------------------
// bbc_ctrl: request sequencer
// Steps a request through tag scan (gets only), target read, update and result hand-off.
// ---------------------------------------------------------------------------
module bbc_ctrl
  import bbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = stat_i.in_get ? S_SCAN : S_LOOKUP;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: state_d = S_LOOKUP;
      S_LOOKUP:   state_d = S_MODIFY;
      S_MODIFY:   state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
      end
      S_SCAN:   cmd_o.scan_rd = 1'b1;
      S_MODIFY: cmd_o.modify  = 1'b1;
      S_DONE:   cmd_o.push    = stat_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/bbc_datapath.sv @@
// ---------------------------------------------------------------------------
// bbc_datapath: slot store, scan trackers and result register
// Holds the slot entries in a memory, tracks hit and victim during the scan
// and applies the read-modify-write of the addressed slot.
// ---------------------------------------------------------------------------
module bbc_datapath
  import bbc_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  req_e              req_type_i,
  input  logic [DEV_W-1:0]  device_i,
  input  logic [BLK_W-1:0]  block_number_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic [STAMP_W-1:0] now_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_o
);

  localparam int IDXW = $clog2(NUM_SLOTS);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // latched request
  req_e               req_type_q;
  logic [DEV_W-1:0]   device_q;
  logic [BLK_W-1:0]   block_q;
  logic [SLOT_W-1:0]  slot_idx_q;
  logic [STAMP_W-1:0] now_q;
  logic               in_range_q;

  // slot store
  entry_t                 mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   ent_valid_q;
  logic [NUM_SLOTS-1:0]   dv_q;

  logic [IDXW-1:0] ptr_q;
  logic [IDXW-1:0] rd_addr;
  entry_t          rd_q;
  logic [IDXW-1:0] rd_idx_q;
  logic            rd_ev_q, rd_dv_q;
  logic            eval_q;
  entry_t          ent;

  // scan trackers
  logic               found_q;
  logic [IDXW-1:0]    match_q;
  logic               vfound_q;
  logic [IDXW-1:0]    vidx_q;
  logic [STAMP_W-1:0] vstamp_q;

  logic    wr_en;
  entry_t  wr_ent;
  result_t res_d, res_q;
  result_t out_q;
  logic    out_valid_q;

  assign stat_o.in_get    = (req_type_i == REQ_GET);
  assign stat_o.scan_last = (ptr_q == IDXW'(NUM_SLOTS - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q <= req_type_i;
      device_q   <= device_i;
      block_q    <= block_number_i;
      slot_idx_q <= slot_index_i;
      now_q      <= now_i;
      in_range_q <= (int'(slot_index_i) < NUM_SLOTS);
    end
  end

  always_comb begin
    if (cmd_i.scan_rd) begin
      rd_addr = ptr_q;
    end else if (req_type_q == REQ_GET) begin
      rd_addr = found_q ? match_q : vidx_q;
    end else if (in_range_q) begin
      rd_addr = IDXW'(slot_idx_q);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (cmd_i.modify && wr_en) begin
      mem_q[rd_idx_q] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      rd_ev_q     <= 1'b0;
      rd_dv_q     <= 1'b0;
      eval_q      <= 1'b0;
      ptr_q       <= '0;
      ent_valid_q <= '0;
      dv_q        <= '0;
    end else begin
      rd_idx_q <= rd_addr;
      rd_ev_q  <= ent_valid_q[rd_addr];
      rd_dv_q  <= dv_q[rd_addr];
      eval_q   <= cmd_i.scan_rd;
      if (cmd_i.accept) begin
        ptr_q <= '0;
      end else if (cmd_i.scan_rd) begin
        ptr_q <= IDXW'(ptr_q + 1'b1);
      end
      if (cmd_i.modify && wr_en) begin
        ent_valid_q[rd_idx_q] <= 1'b1;
        // every write comes from a get or a count change; only get sets it
        if (req_type_q == REQ_GET) begin
          dv_q[rd_idx_q] <= 1'b1;
        end
      end
    end
  end

  // never-written entries read as the reset value
  assign ent = rd_ev_q ? rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      match_q  <= '0;
      vfound_q <= 1'b0;
      vidx_q   <= '0;
      vstamp_q <= '0;
    end else if (cmd_i.accept) begin
      found_q  <= 1'b0;
      match_q  <= '0;
      vfound_q <= 1'b0;
      vidx_q   <= '0;
      vstamp_q <= '0;
    end else if (eval_q) begin
      if (!found_q && ent.dev == device_q && ent.blk == block_q) begin
        found_q <= 1'b1;
        match_q <= rd_idx_q;
      end
      // strict less keeps the lowest slot on equal stamps
      if (ent.cnt == '0 && (!vfound_q || ent.stamp < vstamp_q)) begin
        vfound_q <= 1'b1;
        vidx_q   <= rd_idx_q;
        vstamp_q <= ent.stamp;
      end
    end
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_ent = ent;
    res_d  = '{status: STAT_OK, fill: 1'b0, hit: 1'b0, slot: slot_idx_q};
    case (req_type_q)
      REQ_GET: begin
        if (found_q) begin
          wr_en = 1'b1;
          if (ent.cnt != CNT_MAX) begin
            wr_ent.cnt = ent.cnt + 1'b1;
          end
          res_d = '{status: STAT_OK, fill: !rd_dv_q, hit: 1'b1,
                    slot: SLOT_W'(rd_idx_q)};
        end else if (vfound_q) begin
          wr_en      = 1'b1;
          wr_ent.dev = device_q;
          wr_ent.blk = block_q;
          wr_ent.cnt = CNT_W'(1);
          res_d = '{status: STAT_OK, fill: 1'b1, hit: 1'b0,
                    slot: SLOT_W'(rd_idx_q)};
        end else begin
          res_d = '{status: STAT_NOFREE, fill: 1'b0, hit: 1'b0, slot: '0};
        end
      end
      REQ_PIN: begin
        if (in_range_q && ent.cnt != CNT_MAX) begin
          wr_en      = 1'b1;
          wr_ent.cnt = ent.cnt + 1'b1;
        end
      end
      default: begin
        if (in_range_q) begin
          if (ent.cnt == '0) begin
            res_d.status = STAT_UNDER;
          end else begin
            wr_en      = 1'b1;
            wr_ent.cnt = ent.cnt - 1'b1;
            if (req_type_q == REQ_RELEASE && ent.cnt == CNT_W'(1)) begin
              wr_ent.stamp = now_q;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.modify) begin
      res_q <= res_d;
    end
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ hw/rtl/block_buffer_cache_lru_unit.sv @@
// ---------------------------------------------------------------------------
// block_buffer_cache_lru_unit: buffer cache slot manager with LRU recycling
// Fully associative get/release/pin/unpin over NUM_SLOTS reference-counted
// slots; one result per request.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, the kind in tuser; each one gives
//   exactly one result on the m_axis channel.
//   One request is handled at a time. A get reads every slot through one
//   memory port, one slot a cycle, tracking the first tag match and the
//   oldest unreferenced slot, then reads and rewrites the chosen slot.
//   Release, pin and unpin skip the scan and go straight to the addressed slot.
//   The result sits in an output register; the next request is taken while
//   it waits, but that request's result holds until the register frees.
//   A stalled receiver therefore stops the block after one more request.
//   Reset empties the output register and returns every slot to tag
//   device 0, block 0, count 0, stamp 0, data not valid at once, through
//   one valid flag per slot; no clearing pass.
// ---------------------------------------------------------------------------
module block_buffer_cache_lru_unit
  import bbc_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // device [7:0], block_number [39:8], slot_index [44:40], now [76:45]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // req_type [1:0]
  input  logic [S_USER_W-1:0] s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // slot [4:0], hit [5], needs_fill [6], status [8:7]
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  stat_t   stat;
  result_t res;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bbc_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_e'(s_axis_tuser)),
    .device_i       (s_axis_tdata[7:0]),
    .block_number_i (s_axis_tdata[39:8]),
    .slot_index_i   (s_axis_tdata[44:40]),
    .now_i          (s_axis_tdata[76:45]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_o          (res)
  );

  assign m_axis_tdata = {7'b0, res.status, res.fill, res.hit, res.slot};

endmodule

@@ hw/rtl/bbc_checker.sv @@
// ---------------------------------------------------------------------------
// bbc_checker: port-level checks for the slot manager
// Watches the top level's channels and flags impossible results.
// ---------------------------------------------------------------------------
module bbc_checker
  import bbc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_valid_i,
  input logic                s_ready_i,
  input logic                m_valid_i,
  input logic                m_ready_i,
  input logic [M_DATA_W-1:0] m_data_i
);

  // one request in flight: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_i |=> !s_ready_i)
    else $error("request accepted in consecutive cycles");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i |-> m_data_i[8:7] != 2'd3 && m_data_i[15:9] == '0)
    else $error("malformed result");

  // a hit is always ok; an error never asks for a fill
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && m_data_i[8:7] != STAT_OK |-> !m_data_i[5] && !m_data_i[6])
    else $error("error result with hit or fill set");

  a_nofree_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_i && m_data_i[8:7] == STAT_NOFREE |-> m_data_i[4:0] == '0)
    else $error("no-free result with nonzero slot");

endmodule

bind block_buffer_cache_lru_unit bbc_checker u_bbc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_valid_i (s_axis_tvalid),
  .s_ready_i (s_axis_tready),
  .m_valid_i (m_axis_tvalid),
  .m_ready_i (m_axis_tready),
  .m_data_i  (m_axis_tdata)
);
